>>> rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PPG_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/ppg_pkg.sv
package ppg_pkg;

   // q16 constants
   localparam int Q_ONE    = 65536;
   localparam int Q_C02    = 13107;
   localparam int Q_C002   = 1311;
   localparam int Q_C0075  = 4915;
   localparam int Q_C0055  = 3604;
   localparam int Q_C004   = 2621;
   localparam int Q_PI     = 205887;
   localparam int Q_HALFPI = 102944;
   localparam int Q_TWOPI  = 411775;
   localparam int Q_GAIN   = 39797;

   localparam int MAX_ITERS  = 24;
   localparam int ITER_W     = 5;
   localparam int REDUCE_TOP = 12;
   localparam int SQRT_TOP   = 19;

   typedef struct packed {
      logic       new_frame;
      logic [6:0] x_pos;
      logic [5:0] y_pos;
   } ppg_req_type;

   typedef struct packed {
      logic [3:0] shade_level;
      logic [7:0] glyph_code;
   } ppg_rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_T,
      OP_K,
      OP_ANG_K,
      OP_ANG_2K,
      OP_ANG_3K,
      OP_ANG_4K,
      OP_ST_S1,
      OP_ST_C2,
      OP_ST_C3,
      OP_ST_S4,
      OP_P1A,
      OP_P1B,
      OP_P2A,
      OP_P2B,
      OP_ANG_1,
      OP_ANG_2,
      OP_ANG_3,
      OP_ANG_4,
      OP_ANG_5,
      OP_ADD_SIN_SUM,
      OP_ADD_COS_34,
      OP_ADD_SIN_34,
      OP_OUT
   } ppg_op_type;

   typedef struct packed {
      ppg_op_type op;
      logic       trig_go;
      logic       sqrt_go;
   } ppg_cmd_type;

   typedef struct packed {
      logic trig_done;
      logic sqrt_done;
   } ppg_status_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_T, ST_K,
      ST_AK1, ST_G1, ST_W1,
      ST_AK2, ST_G2, ST_W2,
      ST_AK3, ST_G3, ST_W3,
      ST_AK4, ST_G4, ST_W4,
      ST_P1A, ST_P1B, ST_A1, ST_G5, ST_W5,
      ST_P2A, ST_P2B, ST_A2, ST_G6, ST_W6,
      ST_A3, ST_G7, ST_W7,
      ST_A4, ST_G8, ST_W8,
      ST_SQ, ST_SQW,
      ST_A5, ST_G9, ST_W9,
      ST_OUT
   } ppg_state_type;

   typedef enum logic [1:0] {
      TP_IDLE,
      TP_REDUCE,
      TP_FOLD,
      TP_ROTATE
   } ppg_trig_phase_type;

   function automatic logic [15:0] atan_q(input logic [ITER_W-1:0] i);
      logic [15:0] r;
      unique case (i)
         5'd0:    r = 16'd51472;
         5'd1:    r = 16'd30385;
         5'd2:    r = 16'd16055;
         5'd3:    r = 16'd8150;
         5'd4:    r = 16'd4091;
         5'd5:    r = 16'd2047;
         5'd6:    r = 16'd1024;
         5'd7:    r = 16'd512;
         5'd8:    r = 16'd256;
         5'd9:    r = 16'd128;
         5'd10:   r = 16'd64;
         5'd11:   r = 16'd32;
         5'd12:   r = 16'd16;
         5'd13:   r = 16'd8;
         5'd14:   r = 16'd4;
         5'd15:   r = 16'd2;
         5'd16:   r = 16'd1;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] glyph_of(input logic [3:0] lvl);
      logic [7:0] g;
      unique case (lvl)
         4'd0:    g = 8'd32;
         4'd1:    g = 8'd46;
         4'd2:    g = 8'd43;
         4'd3:    g = 8'd120;
         4'd4:    g = 8'd120;
         4'd5:    g = 8'd88;
         4'd6:    g = 8'd120;
         4'd7:    g = 8'd120;
         4'd8:    g = 8'd43;
         4'd9:    g = 8'd46;
         default: g = 8'd32;
      endcase
      return g;
   endfunction

endpackage

>>> rtl/ppg_trig.sv
`include "assert_macros.svh"

module ppg_trig #(
   parameter int CORDIC_ITERS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic signed [31:0] ang,
   output logic signed [19:0] sin_out,
   output logic signed [19:0] cos_out,
   output logic               done
);

   ppg_pkg::ppg_trig_phase_type phase_ff, phase_in;
   logic done_ff, done_in;

   logic [31:0] mag_ff;
   logic        neg_ff;
   logic [3:0]  j_ff;
   logic signed [19:0] x_ff, y_ff, z_ff;
   logic [ppg_pkg::ITER_W-1:0] i_ff;
   logic        negcos_ff;

   logic [31:0] mod_val;
   logic        last;
   logic signed [20:0] m, r0, r1, r2;
   logic        fold_neg;
   logic signed [19:0] dx, dy, at;

   assign mod_val = 32'(ppg_pkg::Q_TWOPI) << j_ff;
   assign last    = (i_ff == ppg_pkg::ITER_W'(CORDIC_ITERS - 1));
   assign dx      = y_ff >>> i_ff;
   assign dy      = x_ff >>> i_ff;
   assign at      = $signed({4'b0, ppg_pkg::atan_q(i_ff)});

   // fold reduced angle into [-pi/2, pi/2]
   always_comb begin
      m  = $signed({2'b0, mag_ff[18:0]});
      r0 = neg_ff ? -m : m;
      if (r0 < 0) begin
         r0 = r0 + 21'(ppg_pkg::Q_TWOPI);
      end
      r1 = (r0 > 21'(ppg_pkg::Q_PI)) ? r0 - 21'(ppg_pkg::Q_TWOPI) : r0;
      fold_neg = 1'b0;
      r2 = r1;
      priority if (r1 > 21'(ppg_pkg::Q_HALFPI)) begin
         r2 = 21'(ppg_pkg::Q_PI) - r1;
         fold_neg = 1'b1;
      end else if (r1 < -21'(ppg_pkg::Q_HALFPI)) begin
         r2 = -21'(ppg_pkg::Q_PI) - r1;
         fold_neg = 1'b1;
      end else begin
         r2 = r1;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         ppg_pkg::TP_IDLE: begin
            if (go) begin
               phase_in = ppg_pkg::TP_REDUCE;
            end
         end
         ppg_pkg::TP_REDUCE: begin
            if (j_ff == 4'd0) begin
               phase_in = ppg_pkg::TP_FOLD;
            end
         end
         ppg_pkg::TP_FOLD: begin
            phase_in = ppg_pkg::TP_ROTATE;
         end
         ppg_pkg::TP_ROTATE: begin
            if (last) begin
               phase_in = ppg_pkg::TP_IDLE;
               done_in  = 1'b1;
            end
         end
         default: phase_in = ppg_pkg::TP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ppg_pkg::TP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (phase_ff)
         ppg_pkg::TP_IDLE: begin
            if (go) begin
               mag_ff <= ang[31] ? 32'(-ang) : 32'(ang);
               neg_ff <= ang[31];
               j_ff   <= 4'(ppg_pkg::REDUCE_TOP);
            end
         end
         ppg_pkg::TP_REDUCE: begin
            if (mag_ff >= mod_val) begin
               mag_ff <= mag_ff - mod_val;
            end
            j_ff <= j_ff - 4'd1;
         end
         ppg_pkg::TP_FOLD: begin
            z_ff      <= 20'(r2);
            x_ff      <= 20'(ppg_pkg::Q_GAIN);
            y_ff      <= 20'sd0;
            i_ff      <= '0;
            negcos_ff <= fold_neg;
         end
         ppg_pkg::TP_ROTATE: begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + at;
            end
            i_ff <= i_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign sin_out = y_ff;
   assign cos_out = negcos_ff ? -x_ff : x_ff;
   assign done    = done_ff;

   `PPG_ASSERT(a_go_when_idle, clock, reset, go, phase_ff == ppg_pkg::TP_IDLE)
   `PPG_ASSERT(a_done_at_idle, clock, reset, done_ff, phase_ff == ppg_pkg::TP_IDLE)

endmodule

>>> rtl/ppg_dp.sv
`include "assert_macros.svh"

module ppg_dp #(
   parameter int SCREEN_W     = 128,
   parameter int SCREEN_H     = 64,
   parameter int CORDIC_ITERS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ppg_pkg::ppg_req_type    req_word,
   input  ppg_pkg::ppg_cmd_type    cmd,
   output ppg_pkg::ppg_status_type status,
   output ppg_pkg::ppg_rsp_type    rsp_word
);

   logic [15:0] frame_ff;
   logic [6:0]  x_ff, x_in;
   logic [5:0]  y_ff, y_in;
   logic signed [31:0] t_ff, k_ff, acc_ff, ang_ff, sum_ff, v34_ff;
   logic signed [19:0] s1_ff, c2_ff, c3_ff, s4_ff;
   ppg_pkg::ppg_rsp_type rsp_ff;

   logic signed [31:0] mul_a;
   logic signed [19:0] mul_b;
   logic signed [51:0] prod;
   logic signed [31:0] prod_q;

   logic signed [19:0] trig_sin, trig_cos;
   logic               trig_done;

   logic [39:0] sq_n_ff, sq_res_ff, sq_bit, sq_cand;
   logic [4:0]  sq_idx_ff;
   logic        sq_busy_ff, sq_done_ff;

   logic [15:0] q_prod;
   logic [7:0]  q3;
   logic [15:0] d_prod;
   logic [3:0]  d10;
   logic [7:0]  lvl_wide;
   logic [3:0]  lvl;

   function automatic logic signed [31:0] tenfold(input logic signed [19:0] s);
      logic signed [31:0] e;
      e = $signed({{12{s[19]}}, s});
      return 32'(10 * ppg_pkg::Q_ONE) + (e <<< 3) + (e <<< 1);
   endfunction

   // off-screen coordinates clamp to the last column or row
   always_comb begin
      x_in = req_word.x_pos;
      y_in = req_word.y_pos;
      if (int'(req_word.x_pos) >= SCREEN_W) begin
         x_in = 7'(SCREEN_W - 1);
      end
      if (int'(req_word.y_pos) >= SCREEN_H) begin
         y_in = 6'(SCREEN_H - 1);
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         ppg_pkg::OP_T: begin
            mul_a = $signed({16'b0, frame_ff});
            mul_b = 20'(ppg_pkg::Q_C02);
         end
         ppg_pkg::OP_K: begin
            mul_a = t_ff + $signed({10'b0, y_ff, 16'b0});
            mul_b = 20'(ppg_pkg::Q_C002);
         end
         ppg_pkg::OP_P1A: begin
            mul_a = $signed({25'b0, x_ff});
            mul_b = s1_ff;
         end
         ppg_pkg::OP_P1B: begin
            mul_a = $signed({25'b0, y_ff, 1'b0});
            mul_b = c2_ff;
         end
         ppg_pkg::OP_P2A: begin
            mul_a = $signed({25'b0, x_ff});
            mul_b = c3_ff;
         end
         ppg_pkg::OP_P2B: begin
            mul_a = $signed({25'b0, y_ff, 1'b0});
            mul_b = s4_ff;
         end
         ppg_pkg::OP_ANG_1: begin
            mul_a = acc_ff;
            mul_b = 20'(ppg_pkg::Q_C0075);
         end
         ppg_pkg::OP_ANG_2: begin
            mul_a = acc_ff;
            mul_b = 20'(ppg_pkg::Q_C0055);
         end
         ppg_pkg::OP_ANG_3: begin
            mul_a = t_ff + $signed({9'b0, y_ff, 17'b0});
            mul_b = 20'(ppg_pkg::Q_C004);
         end
         ppg_pkg::OP_ANG_4: begin
            mul_a = t_ff + $signed({9'b0, x_ff, 16'b0});
            mul_b = 20'(ppg_pkg::Q_C004);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod   = mul_a * mul_b;
   assign prod_q = prod[47:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else if (cmd.op == ppg_pkg::OP_LOAD) begin
         frame_ff <= frame_ff + 16'(req_word.new_frame);
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         ppg_pkg::OP_LOAD: begin
            x_ff   <= x_in;
            y_ff   <= y_in;
            sum_ff <= '0;
            v34_ff <= '0;
         end
         ppg_pkg::OP_T:      t_ff   <= prod[31:0];
         ppg_pkg::OP_K:      k_ff   <= prod_q;
         ppg_pkg::OP_ANG_K:  ang_ff <= k_ff;
         ppg_pkg::OP_ANG_2K: ang_ff <= k_ff <<< 1;
         ppg_pkg::OP_ANG_3K: ang_ff <= k_ff + (k_ff <<< 1);
         ppg_pkg::OP_ANG_4K: ang_ff <= k_ff <<< 2;
         ppg_pkg::OP_ST_S1:  s1_ff  <= trig_sin;
         ppg_pkg::OP_ST_C2:  c2_ff  <= trig_cos;
         ppg_pkg::OP_ST_C3:  c3_ff  <= trig_cos;
         ppg_pkg::OP_ST_S4:  s4_ff  <= trig_sin;
         ppg_pkg::OP_P1A:    acc_ff <= prod[31:0];
         ppg_pkg::OP_P1B:    acc_ff <= acc_ff + prod[31:0];
         ppg_pkg::OP_P2A:    acc_ff <= prod[31:0];
         ppg_pkg::OP_P2B:    acc_ff <= acc_ff + prod[31:0];
         ppg_pkg::OP_ANG_1:  ang_ff <= prod_q;
         ppg_pkg::OP_ANG_2:  ang_ff <= prod_q;
         ppg_pkg::OP_ANG_3:  ang_ff <= prod_q;
         ppg_pkg::OP_ANG_4:  ang_ff <= prod_q;
         ppg_pkg::OP_ANG_5:  ang_ff <= k_ff + $signed({11'b0, sq_res_ff[20:0]});
         ppg_pkg::OP_ADD_SIN_SUM: sum_ff <= sum_ff + tenfold(trig_sin);
         ppg_pkg::OP_ADD_COS_34:  v34_ff <= v34_ff + tenfold(trig_cos);
         ppg_pkg::OP_ADD_SIN_34:  v34_ff <= v34_ff + tenfold(trig_sin);
         ppg_pkg::OP_OUT: begin
            rsp_ff.shade_level <= lvl;
            rsp_ff.glyph_code  <= ppg_pkg::glyph_of(lvl);
         end
         default: ;
      endcase
   end

   // level: floor(sum / 3.0) mod 10, reciprocal multiplies on the small integer part
   assign q_prod   = 16'(sum_ff[23:16]) * 16'd171;
   assign q3       = q_prod[15:8] >> 1;
   assign d_prod   = 16'(q3) * 16'd205;
   assign d10      = 4'(d_prod >> 11);
   assign lvl_wide = q3 - 8'(d10) * 8'd10;
   assign lvl      = (sum_ff > 0) ? lvl_wide[3:0] : 4'd0;

   // square root, one result bit a cycle
   assign sq_bit  = 40'(1) << {sq_idx_ff, 1'b0};
   assign sq_cand = sq_res_ff + sq_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
         sq_done_ff <= 1'b0;
      end else begin
         sq_done_ff <= 1'b0;
         if (cmd.sqrt_go) begin
            sq_busy_ff <= 1'b1;
         end else if (sq_busy_ff && sq_idx_ff == 5'd0) begin
            sq_busy_ff <= 1'b0;
            sq_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_go) begin
         sq_n_ff   <= (v34_ff > 0) ? {v34_ff[23:0], 16'b0} : 40'd0;
         sq_res_ff <= '0;
         sq_idx_ff <= 5'(ppg_pkg::SQRT_TOP);
      end else if (sq_busy_ff) begin
         if (sq_n_ff >= sq_cand) begin
            sq_n_ff   <= sq_n_ff - sq_cand;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_idx_ff <= sq_idx_ff - 5'd1;
      end
   end

   ppg_trig #(
      .CORDIC_ITERS(CORDIC_ITERS)
   ) u_trig (
      .clock   (clock),
      .reset   (reset),
      .go      (cmd.trig_go),
      .ang     (ang_ff),
      .sin_out (trig_sin),
      .cos_out (trig_cos),
      .done    (trig_done)
   );

   assign status.trig_done = trig_done;
   assign status.sqrt_done = sq_done_ff;
   assign rsp_word         = rsp_ff;

   `PPG_ASSERT(a_sqrt_done_idle, clock, reset, sq_done_ff, !sq_busy_ff)
   `PPG_ASSERT_NEXT(a_sqrt_starts, clock, reset, cmd.sqrt_go, sq_busy_ff)

endmodule

>>> rtl/ppg_ctrl.sv
`include "assert_macros.svh"

module ppg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  ppg_pkg::ppg_status_type status,
   output ppg_pkg::ppg_cmd_type    cmd
);

   ppg_pkg::ppg_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in    = state_ff;
      cmd.op      = ppg_pkg::OP_NONE;
      cmd.trig_go = 1'b0;
      cmd.sqrt_go = 1'b0;
      unique case (state_ff)
         ppg_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = ppg_pkg::OP_LOAD;
               state_in = ppg_pkg::ST_T;
            end
         end
         ppg_pkg::ST_T: begin
            cmd.op = ppg_pkg::OP_T; state_in = ppg_pkg::ST_K;
         end
         ppg_pkg::ST_K: begin
            cmd.op = ppg_pkg::OP_K; state_in = ppg_pkg::ST_AK1;
         end
         ppg_pkg::ST_AK1: begin
            cmd.op = ppg_pkg::OP_ANG_K; state_in = ppg_pkg::ST_G1;
         end
         ppg_pkg::ST_G1: begin
            cmd.trig_go = 1'b1; state_in = ppg_pkg::ST_W1;
         end
         ppg_pkg::ST_W1: begin
            if (status.trig_done) begin
               cmd.op = ppg_pkg::OP_ST_S1; state_in = ppg_pkg::ST_AK2;
            end
         end
         ppg_pkg::ST_AK2: begin
            cmd.op = ppg_pkg::OP_ANG_2K; state_in = ppg_pkg::ST_G2;
         end
         ppg_pkg::ST_G2: begin
            cmd.trig_go = 1'b1; state_in = ppg_pkg::ST_W2;
         end
         ppg_pkg::ST_W2: begin
            if (status.trig_done) begin
               cmd.op = ppg_pkg::OP_ST_C2; state_in = ppg_pkg::ST_AK3;
            end
         end
         ppg_pkg::ST_AK3: begin
            cmd.op = ppg_pkg::OP_ANG_3K; state_in = ppg_pkg::ST_G3;
         end
         ppg_pkg::ST_G3: begin
            cmd.trig_go = 1'b1; state_in = ppg_pkg::ST_W3;
         end
         ppg_pkg::ST_W3: begin
            if (status.trig_done) begin
               cmd.op = ppg_pkg::OP_ST_C3; state_in = ppg_pkg::ST_AK4;
            end
         end
         ppg_pkg::ST_AK4: begin
            cmd.op = ppg_pkg::OP_ANG_4K; state_in = ppg_pkg::ST_G4;
         end
         ppg_pkg::ST_G4: begin
            cmd.trig_go = 1'b1; state_in = ppg_pkg::ST_W4;
         end
         ppg_pkg::ST_W4: begin
            if (status.trig_done) begin
               cmd.op = ppg_pkg::OP_ST_S4; state_in = ppg_pkg::ST_P1A;
            end
         end
         ppg_pkg::ST_P1A: begin
            cmd.op = ppg_pkg::OP_P1A; state_in = ppg_pkg::ST_P1B;
         end
         ppg_pkg::ST_P1B: begin
            cmd.op = ppg_pkg::OP_P1B; state_in = ppg_pkg::ST_A1;
         end
         ppg_pkg::ST_A1: begin
            cmd.op = ppg_pkg::OP_ANG_1; state_in = ppg_pkg::ST_G5;
         end
         ppg_pkg::ST_G5: begin
            cmd.trig_go = 1'b1; state_in = ppg_pkg::ST_W5;
         end
         ppg_pkg::ST_W5: begin
            if (status.trig_done) begin
               cmd.op = ppg_pkg::OP_ADD_SIN_SUM; state_in = ppg_pkg::ST_P2A;
            end
         end
         ppg_pkg::ST_P2A: begin
            cmd.op = ppg_pkg::OP_P2A; state_in = ppg_pkg::ST_P2B;
         end
         ppg_pkg::ST_P2B: begin
            cmd.op = ppg_pkg::OP_P2B; state_in = ppg_pkg::ST_A2;
         end
         ppg_pkg::ST_A2: begin
            cmd.op = ppg_pkg::OP_ANG_2; state_in = ppg_pkg::ST_G6;
         end
         ppg_pkg::ST_G6: begin
            cmd.trig_go = 1'b1; state_in = ppg_pkg::ST_W6;
         end
         ppg_pkg::ST_W6: begin
            if (status.trig_done) begin
               cmd.op = ppg_pkg::OP_ADD_SIN_SUM; state_in = ppg_pkg::ST_A3;
            end
         end
         ppg_pkg::ST_A3: begin
            cmd.op = ppg_pkg::OP_ANG_3; state_in = ppg_pkg::ST_G7;
         end
         ppg_pkg::ST_G7: begin
            cmd.trig_go = 1'b1; state_in = ppg_pkg::ST_W7;
         end
         ppg_pkg::ST_W7: begin
            if (status.trig_done) begin
               cmd.op = ppg_pkg::OP_ADD_COS_34; state_in = ppg_pkg::ST_A4;
            end
         end
         ppg_pkg::ST_A4: begin
            cmd.op = ppg_pkg::OP_ANG_4; state_in = ppg_pkg::ST_G8;
         end
         ppg_pkg::ST_G8: begin
            cmd.trig_go = 1'b1; state_in = ppg_pkg::ST_W8;
         end
         ppg_pkg::ST_W8: begin
            if (status.trig_done) begin
               cmd.op = ppg_pkg::OP_ADD_SIN_34; state_in = ppg_pkg::ST_SQ;
            end
         end
         ppg_pkg::ST_SQ: begin
            cmd.sqrt_go = 1'b1; state_in = ppg_pkg::ST_SQW;
         end
         ppg_pkg::ST_SQW: begin
            if (status.sqrt_done) begin
               state_in = ppg_pkg::ST_A5;
            end
         end
         ppg_pkg::ST_A5: begin
            cmd.op = ppg_pkg::OP_ANG_5; state_in = ppg_pkg::ST_G9;
         end
         ppg_pkg::ST_G9: begin
            cmd.trig_go = 1'b1; state_in = ppg_pkg::ST_W9;
         end
         ppg_pkg::ST_W9: begin
            if (status.trig_done) begin
               cmd.op = ppg_pkg::OP_ADD_SIN_SUM; state_in = ppg_pkg::ST_OUT;
            end
         end
         ppg_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op = ppg_pkg::OP_OUT; state_in = ppg_pkg::ST_IDLE;
            end
         end
         default: state_in = ppg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.op == ppg_pkg::OP_OUT) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ppg_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `PPG_ASSERT(a_no_overwrite, clock, reset, cmd.op == ppg_pkg::OP_OUT, !rsp_valid_ff || !rsp_stall)
   `PPG_ASSERT(a_trig_done_waited, clock, reset, status.trig_done, state_ff == ppg_pkg::ST_W1 || state_ff == ppg_pkg::ST_W2 || state_ff == ppg_pkg::ST_W3 || state_ff == ppg_pkg::ST_W4 || state_ff == ppg_pkg::ST_W5 || state_ff == ppg_pkg::ST_W6 || state_ff == ppg_pkg::ST_W7 || state_ff == ppg_pkg::ST_W8 || state_ff == ppg_pkg::ST_W9)

endmodule

>>> rtl/plasma_pattern_pixel_generator_unit.sv
// plasma pattern pixel generator: takes one screen coordinate word (x_pos, y_pos and a
// new_frame flag that bumps a 16-bit wrapping frame counter first) and returns one word
// with the shade level 0..9 and the glyph byte for that cell. coordinates past the screen
// edge clamp to the last column or row. the nine sine/cosine evaluations share one
// iterative unit (13 range-reduction steps, one fold, CORDIC_ITERS rotations), and
// there is a 20-step square root besides. one word is in work at a time; the next is
// taken once the result sits in the output register, which holds it while rsp_stall is
// high.
module plasma_pattern_pixel_generator_unit #(
   parameter int SCREEN_W     = 128,
   parameter int SCREEN_H     = 64,
   parameter int CORDIC_ITERS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // request side
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ppg_pkg::ppg_req_type req_word,
   // response side
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ppg_pkg::ppg_rsp_type rsp_word
);

   // command and status between sequencer and datapath
   ppg_pkg::ppg_cmd_type    cmd;
   ppg_pkg::ppg_status_type status;

   // sequencer: walks the fixed order of multiplies, trig calls and the root
   ppg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: frame counter, shared multiplier, trig unit, root, output register
   ppg_dp #(
      .SCREEN_W     (SCREEN_W),
      .SCREEN_H     (SCREEN_H),
      .CORDIC_ITERS (CORDIC_ITERS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

endmodule
